@@ rtl/core/uart_rb_pkg.sv @@
`default_nettype none

package uart_rb_pkg;

  // Kind of work carried by one input item.
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_RX    = 2'd2
  } func_e;

  // Register byte offsets.
  localparam logic [11:0] REG_DATA     = 12'h000;
  localparam logic [11:0] REG_RSR      = 12'h004;
  localparam logic [11:0] REG_FLAGS    = 12'h018;
  localparam logic [11:0] REG_IBRD     = 12'h024;
  localparam logic [11:0] REG_FBRD     = 12'h028;
  localparam logic [11:0] REG_LCR      = 12'h02C;
  localparam logic [11:0] REG_CTRL     = 12'h030;
  localparam logic [11:0] REG_IFLS     = 12'h034;
  localparam logic [11:0] REG_IMSC     = 12'h038;
  localparam logic [11:0] REG_RIS      = 12'h03C;
  localparam logic [11:0] REG_MIS      = 12'h040;
  localparam logic [11:0] REG_ICR      = 12'h044;

  // The ID bytes live in the top 32 bytes of the window, one per word.
  localparam logic [6:0]  ID_PAGE      = 7'h7F;

  localparam int          INT_W        = 11;
  localparam int          IRQ_RX_IDX   = 4;
  localparam int          IRQ_TX_IDX   = 5;
  localparam int          FLAG_RXFE    = 4;
  localparam int          FLAG_TXFE    = 7;

  localparam logic [31:0] CTRL_RESET   = 32'h0000_0300;

  function automatic logic [7:0] id_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h11;
      3'd1:    b = 8'h10;
      3'd2:    b = 8'h14;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'h0D;
      3'd5:    b = 8'hF0;
      3'd6:    b = 8'h05;
      3'd7:    b = 8'hB1;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Requests from the register file to the receive FIFO.
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  // One result item.
  typedef struct packed {
    logic [31:0] rdata;
    logic        ok;
    logic        tx_valid;
    logic [7:0]  tx_char;
    logic        irq;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/uart_rb_fifo.sv @@
`default_nettype none

module uart_rb_fifo
  import uart_rb_pkg::*;
#(
  parameter int RX_DEPTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire fifo_ctl_t    ctl,
  input  wire logic [7:0]   wr_data,
  output logic [7:0]        rd_data,
  output fifo_status_t      status
);

  localparam int PTR_W   = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int COUNT_W = $clog2(RX_DEPTH + 1);
  localparam int SUM_W   = COUNT_W + 1;
  localparam logic [PTR_W-1:0]   LAST  = PTR_W'(RX_DEPTH - 1);
  localparam logic [COUNT_W-1:0] DEPTH = COUNT_W'(RX_DEPTH);
  localparam logic [SUM_W-1:0]   DEPTH_S = SUM_W'(RX_DEPTH);

  logic [7:0]         mem [RX_DEPTH];
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   head_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [SUM_W-1:0]   tail_sum;
  logic [PTR_W-1:0]   tail;
  logic [7:0]         rd_q;

  // The tail is head plus fill count, folded once since the head stays below the depth and the count never exceeds it.
  always_comb begin
    tail_sum = SUM_W'(head) + SUM_W'(count);
    if (tail_sum >= DEPTH_S) begin
      tail_sum = tail_sum - DEPTH_S;
    end
    tail = tail_sum[PTR_W-1:0];
  end

  always_comb begin
    head_next  = head;
    count_next = count;
    if (ctl.pop) begin
      head_next  = (head == LAST) ? '0 : head + 1'b1;
      count_next = count - 1'b1;
    end else if (ctl.push) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // The read port always holds the entry at the next head, so a pop finds its
  // data ready. A push into an empty FIFO lands at that entry and is forwarded.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= wr_data;
    end
    if (ctl.push && (tail == head_next)) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= mem[head_next];
    end
  end

  assign rd_data      = rd_q;
  assign status.empty = (count == '0);
  assign status.full  = (count == DEPTH);

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH)
    else $error("receive FIFO fill count beyond depth");

  a_one_op : assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> !ctl.pop)
    else $error("push and pop in the same cycle");

  a_pop_count : assert property (@(posedge clk) disable iff (rst)
    ctl.pop |=> (count == $past(count) - 1'b1))
    else $error("pop did not lower the fill count");

endmodule

`default_nettype wire

@@ rtl/core/uart_rb_regs.sv @@
`default_nettype none

module uart_rb_regs
  import uart_rb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic [1:0]   func,
  input  wire logic [11:0]  offset,
  input  wire logic [31:0]  wdata,
  input  wire logic [7:0]   rx_char,
  input  wire logic [7:0]   fifo_data,
  input  wire fifo_status_t fifo_status,
  output fifo_ctl_t         fifo_ctl,
  output logic [7:0]        fifo_wr_data,
  output result_t           result
);

  logic [31:0]      control_reg;
  logic [31:0]      control_reg_next;
  logic [15:0]      baud_integer;
  logic [15:0]      baud_integer_next;
  logic [5:0]       baud_fraction;
  logic [5:0]       baud_fraction_next;
  logic [7:0]       line_ctrl;
  logic [7:0]       line_ctrl_next;
  logic [31:0]      fifo_level_sel;
  logic [31:0]      fifo_level_sel_next;
  logic [INT_W-1:0] int_mask;
  logic [INT_W-1:0] int_mask_next;
  logic [INT_W-1:0] int_raw;
  logic [INT_W-1:0] int_raw_next;

  always_comb begin
    control_reg_next    = control_reg;
    baud_integer_next   = baud_integer;
    baud_fraction_next  = baud_fraction;
    line_ctrl_next      = line_ctrl;
    fifo_level_sel_next = fifo_level_sel;
    int_mask_next       = int_mask;
    int_raw_next        = int_raw;
    fifo_ctl            = '0;
    result              = '0;

    case (func_e'(func))
      FUNC_READ: begin
        result.ok = 1'b1;
        case (offset)
          REG_DATA: begin
            if (!fifo_status.empty) begin
              result.rdata             = {24'd0, fifo_data};
              fifo_ctl.pop             = en;
              int_raw_next[IRQ_RX_IDX] = 1'b0;
            end
          end
          REG_RSR:   result.rdata = '0;
          REG_FLAGS: begin
            result.rdata[FLAG_RXFE] = fifo_status.empty;
            result.rdata[FLAG_TXFE] = 1'b1;
          end
          REG_IBRD:  result.rdata = {16'd0, baud_integer};
          REG_FBRD:  result.rdata = {26'd0, baud_fraction};
          REG_LCR:   result.rdata = {24'd0, line_ctrl};
          REG_CTRL:  result.rdata = control_reg;
          REG_IFLS:  result.rdata = fifo_level_sel;
          REG_IMSC:  result.rdata = {21'd0, int_mask};
          REG_RIS:   result.rdata = {21'd0, int_raw};
          REG_MIS:   result.rdata = {21'd0, int_raw & int_mask};
          default: begin
            if ((offset[11:5] == ID_PAGE) && (offset[1:0] == 2'b00)) begin
              result.rdata = {24'd0, id_byte(offset[4:2])};
            end else begin
              result.ok = 1'b0;
            end
          end
        endcase
      end
      FUNC_WRITE: begin
        case (offset)
          REG_DATA: begin
            int_raw_next[IRQ_TX_IDX] = 1'b1;
            result.tx_valid          = 1'b1;
            result.tx_char           = wdata[7:0];
          end
          REG_IBRD: baud_integer_next   = wdata[15:0];
          REG_FBRD: baud_fraction_next  = wdata[5:0];
          REG_LCR:  line_ctrl_next      = wdata[7:0];
          REG_CTRL: control_reg_next    = wdata;
          REG_IFLS: fifo_level_sel_next = wdata;
          REG_IMSC: int_mask_next       = wdata[INT_W-1:0];
          REG_ICR:  int_raw_next        = int_raw & ~wdata[INT_W-1:0];
          default:  ;
        endcase
      end
      FUNC_RX: begin
        // A character that finds the FIFO full is lost, but still raises the flag.
        fifo_ctl.push            = en && !fifo_status.full;
        int_raw_next[IRQ_RX_IDX] = 1'b1;
      end
      default: ;
    endcase

    result.irq = |(int_raw_next & int_mask_next);
  end

  assign fifo_wr_data = rx_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg    <= CTRL_RESET;
      baud_integer   <= '0;
      baud_fraction  <= '0;
      line_ctrl      <= '0;
      fifo_level_sel <= '0;
      int_mask       <= '0;
      int_raw        <= '0;
    end else if (en) begin
      control_reg    <= control_reg_next;
      baud_integer   <= baud_integer_next;
      baud_fraction  <= baud_fraction_next;
      line_ctrl      <= line_ctrl_next;
      fifo_level_sel <= fifo_level_sel_next;
      int_mask       <= int_mask_next;
      int_raw        <= int_raw_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/uart_register_block_rx_fifo.sv @@
// UART register block with a receive FIFO and a maskable interrupt. Each item
// is a bus read, a bus write or a received character, and each item yields
// exactly one result item in order. An item is registered on acceptance,
// decoded and applied to the registers and FIFO when it moves on to the
// result register, which an output stall can hold off, and its result is
// held in that output register until taken; with no stall on the output a
// new item is taken every cycle. The item passes through the input register
// and then the result register, from which the result is presented. The
// receive FIFO holds RX_DEPTH characters in a memory whose read port is
// always primed with the entry at the head, so a data register read returns
// its character in the same cycle it is processed. Characters arriving at a
// full FIFO are dropped, though the RX interrupt bit is still set. The irq
// field reflects the interrupt level after the item has taken effect.

`default_nettype none

module uart_register_block_rx_fifo
  import uart_rb_pkg::*;
#(
  parameter int RX_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [11:0] offset,
  input  wire logic [31:0] wdata,
  input  wire logic [7:0]  rx_char,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      rdata,
  output logic             ok,
  output logic             tx_valid,
  output logic [7:0]       tx_char,
  output logic             irq
);

  // Input register.
  logic        s1_valid;
  logic [1:0]  s1_func;
  logic [11:0] s1_offset;
  logic [31:0] s1_wdata;
  logic [7:0]  s1_rx_char;

  // Result register.
  result_t     res;
  result_t     res_next;

  logic         advance;
  logic         accept;
  fifo_ctl_t    fifo_ctl;
  fifo_status_t fifo_status;
  logic [7:0]   fifo_rd_data;
  logic [7:0]   fifo_wr_data;

  // The held item moves on whenever the result register is free or being
  // emptied in this cycle.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func    <= func;
      s1_offset  <= offset;
      s1_wdata   <= wdata;
      s1_rx_char <= rx_char;
    end
  end

  uart_rb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .en           (advance),
    .func         (s1_func),
    .offset       (s1_offset),
    .wdata        (s1_wdata),
    .rx_char      (s1_rx_char),
    .fifo_data    (fifo_rd_data),
    .fifo_status  (fifo_status),
    .fifo_ctl     (fifo_ctl),
    .fifo_wr_data (fifo_wr_data),
    .result       (res_next)
  );

  uart_rb_fifo #(
    .RX_DEPTH (RX_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .ctl     (fifo_ctl),
    .wr_data (fifo_wr_data),
    .rd_data (fifo_rd_data),
    .status  (fifo_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign rdata    = res.rdata;
  assign ok       = res.ok;
  assign tx_valid = res.tx_valid;
  assign tx_char  = res.tx_char;
  assign irq      = res.irq;

  a_stall_needs_item : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with no item held");

  a_advance_fills_out : assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed item produced no result");

  a_drain_empties : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !s1_valid) |=> !out_valid)
    else $error("result repeated after it was taken");

endmodule

`default_nettype wire
